[sv/chd_pkg.sv]
package chd_pkg;

   localparam int MAX_CODE_LEN = 16;
   localparam int SYMBOL_COUNT = 256;

   localparam int SYM_W   = 8;
   localparam int CLEN_W  = 5;
   localparam int CFG_W   = 16;
   localparam int CODE_W  = 32;
   localparam int SYM_IW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int SCAN_W  = $clog2(SYMBOL_COUNT + 1);
   localparam int CNT_W   = $clog2(SYMBOL_COUNT + 1);
   localparam int LEN_IW  = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
   localparam int BITS_W  = $clog2(MAX_CODE_LEN + 1);
   localparam int IDX_W   = (SCAN_W > BITS_W) ? SCAN_W : BITS_W;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_START = 2'd2,
      OP_BIT   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_HIST,
      ST_PREFIX,
      ST_PLACE
   } state_type;

   typedef struct packed {
      logic load_we;
      logic dec_clear;
      logic dec_bit;
      logic tab_clear;
      logic scan_rd;
      logic place;
      logic prefix_step;
      logic idx_clear;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
      logic idx_end;
      logic idx_lastlen;
      logic rd_live;
   } status_type;

endpackage

[sv/chd_ctrl.sv]
module chd_ctrl import chd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  op_type     req_op,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // a waiting result must leave this cycle before a new request enters
            req_tready = !status.rsp_busy || rsp_tready;
            if (req_tvalid && req_tready) begin
               case (req_op)
                  OP_LOAD:  cmd.load_we   = 1'b1;
                  OP_BUILD: state_in      = ST_CLEAR;
                  OP_START: cmd.dec_clear = 1'b1;
                  OP_BIT:   cmd.dec_bit   = 1'b1;
                  default:  cmd.load_we   = 1'b0;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.tab_clear = 1'b1;
            state_in      = ST_HIST;
         end
         ST_HIST: begin
            if (!status.idx_end) begin
               cmd.scan_rd = 1'b1;
            end else if (!status.rd_live) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            cmd.prefix_step = 1'b1;
            if (status.idx_lastlen) begin
               cmd.idx_clear = 1'b1;
               state_in      = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (!status.idx_end) begin
               cmd.scan_rd = 1'b1;
               cmd.place   = 1'b1;
            end else if (!status.rd_live) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[sv/chd_datapath.sv]
module chd_datapath import chd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [SYM_W-1:0]  in_symbol,
   input  logic [CLEN_W-1:0] in_length,
   input  logic              in_bit,
   input  logic              csr_valid,
   input  logic [CFG_W-1:0]  csr_data,
   input  logic              rsp_tready,
   output logic              rsp_valid,
   output logic [SYM_W-1:0]  rsp_symbol,
   output logic              rsp_done,
   output logic              rsp_bad
);

   logic [CFG_W-1:0]  expected_ff;

   // code length store, with a valid bit per entry so reset reads as unused
   logic [CLEN_W-1:0] len_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] len_vld_ff;
   logic [SYM_W-1:0]  sorted_mem [SYMBOL_COUNT];

   logic [CODE_W-1:0] first_code_ff [MAX_CODE_LEN];
   logic [CNT_W-1:0]  count_ff      [MAX_CODE_LEN];
   logic [CNT_W-1:0]  offset_ff     [MAX_CODE_LEN];
   logic [CNT_W-1:0]  fill_ff       [MAX_CODE_LEN];
   logic [CODE_W-1:0] code_acc_ff;
   logic [CNT_W-1:0]  filled_ff;
   logic [IDX_W-1:0]  idx_ff;

   logic              rd_live_ff;
   logic              rd_place_ff;
   logic [SYM_IW-1:0] rd_sym_ff;
   logic [CLEN_W-1:0] rd_len_ff;
   logic              rd_vld_ff;

   logic [MAX_CODE_LEN-1:0] partial_ff;
   logic [BITS_W-1:0]       bits_ff;
   logic [CFG_W-1:0]        emitted_ff;
   logic                    halted_ff;

   logic              rsp_valid_ff;
   logic              rsp_done_ff;
   logic              rsp_bad_ff;
   logic [SYM_W-1:0]  sym_q_ff;

   logic              load_ok;
   logic [SYM_IW-1:0] load_addr;
   logic [SYM_IW-1:0] scan_addr;
   logic [LEN_IW-1:0] pli;
   logic [CLEN_W-1:0] rd_len_eff;
   logic              rd_len_ok;
   logic [LEN_IW-1:0] rd_li;
   logic              hist_go;
   logic              place_go;

   logic                    dec_go;
   logic [MAX_CODE_LEN-1:0] pc_next;
   logic [BITS_W-1:0]       bt_next;
   logic [LEN_IW-1:0]       dli;
   logic [CODE_W-1:0]       diff;
   logic                    match;
   logic [CNT_W-1:0]        pos_sum;
   logic [SYM_IW-1:0]       dec_pos;
   logic [CFG_W-1:0]        emit_next;
   logic                    hit_end;
   logic                    overflow;

   assign load_ok   = int'(in_symbol) < SYMBOL_COUNT;
   assign load_addr = in_symbol[SYM_IW-1:0];
   assign scan_addr = idx_ff[SYM_IW-1:0];
   assign pli       = idx_ff[LEN_IW-1:0];

   assign rd_len_eff = rd_vld_ff ? rd_len_ff : '0;
   // lengths above the maximum are kept in the store but skipped here
   assign rd_len_ok  = (rd_len_eff != '0) && (int'(rd_len_eff) <= MAX_CODE_LEN);
   assign rd_li      = LEN_IW'(rd_len_eff - 1'b1);
   assign hist_go    = rd_live_ff && !rd_place_ff && rd_len_ok;
   assign place_go   = rd_live_ff && rd_place_ff && rd_len_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (csr_valid) begin
         expected_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we && load_ok) begin
         len_mem[load_addr] <= in_length;
      end
      if (cmd.scan_rd) begin
         rd_len_ff <= len_mem[scan_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_vld_ff <= '0;
      end else if (cmd.load_we && load_ok) begin
         len_vld_ff[load_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         rd_vld_ff <= len_vld_ff[scan_addr];
         rd_sym_ff <= scan_addr;
      end
      rd_place_ff <= cmd.place;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         rd_live_ff <= cmd.scan_rd;
         if (cmd.idx_clear || cmd.tab_clear) begin
            idx_ff <= '0;
         end else if (cmd.scan_rd || cmd.prefix_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // per-length symbol counts; zero counts keep an unbuilt decoder from matching
   always_ff @(posedge clock) begin
      if (reset || cmd.tab_clear) begin
         for (int i = 0; i < MAX_CODE_LEN; i++) begin
            count_ff[i] <= '0;
         end
      end else if (hist_go) begin
         count_ff[rd_li] <= count_ff[rd_li] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CODE_LEN; i++) begin
            first_code_ff[i] <= '0;
            offset_ff[i]     <= '0;
         end
      end else if (cmd.prefix_step) begin
         first_code_ff[pli] <= code_acc_ff;
         offset_ff[pli]     <= filled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tab_clear) begin
         code_acc_ff <= '0;
         filled_ff   <= '0;
      end
      if (cmd.prefix_step) begin
         fill_ff[pli]       <= filled_ff;
         code_acc_ff        <= (code_acc_ff + CODE_W'(count_ff[pli])) << 1;
         filled_ff          <= filled_ff + count_ff[pli];
      end
      if (place_go) begin
         fill_ff[rd_li] <= fill_ff[rd_li] + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (place_go) begin
         sorted_mem[fill_ff[rd_li][SYM_IW-1:0]] <= rd_sym_ff;
      end
      if (dec_go && match) begin
         sym_q_ff <= sorted_mem[dec_pos];
      end
   end

   assign dec_go  = cmd.dec_bit && !halted_ff;
   assign pc_next = (partial_ff << 1) | MAX_CODE_LEN'(in_bit);
   assign bt_next = bits_ff + 1'b1;
   // table slot for the new length is the old bit count
   assign dli     = bits_ff[LEN_IW-1:0];
   assign diff    = CODE_W'(pc_next) - first_code_ff[dli];
   assign match   = diff < CODE_W'(count_ff[dli]);
   // offset + diff stays below the number of placed symbols, so no wrap is needed
   assign pos_sum = offset_ff[dli] + diff[CNT_W-1:0];
   assign dec_pos = pos_sum[SYM_IW-1:0];
   assign emit_next = emitted_ff + 1'b1;
   assign hit_end   = (expected_ff != '0) && (emit_next == expected_ff);
   assign overflow  = bt_next == BITS_W'(MAX_CODE_LEN);

   always_ff @(posedge clock) begin
      if (reset || cmd.dec_clear) begin
         partial_ff <= '0;
         bits_ff    <= '0;
         emitted_ff <= '0;
         halted_ff  <= 1'b0;
      end else if (dec_go) begin
         if (match) begin
            partial_ff <= '0;
            bits_ff    <= '0;
            emitted_ff <= emit_next;
            if (hit_end) begin
               halted_ff <= 1'b1;
            end
         end else begin
            partial_ff <= pc_next;
            bits_ff    <= bt_next;
            if (overflow) begin
               halted_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dec_go && (match || overflow)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dec_go) begin
         rsp_done_ff <= match && hit_end;
         rsp_bad_ff  <= !match;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_bad_ff ? '0 : sym_q_ff;
   assign rsp_done   = rsp_done_ff;
   assign rsp_bad    = rsp_bad_ff;

   assign status.rsp_busy    = rsp_valid_ff;
   assign status.idx_end     = idx_ff == IDX_W'(SYMBOL_COUNT);
   assign status.idx_lastlen = idx_ff == IDX_W'(MAX_CODE_LEN - 1);
   assign status.rd_live     = rd_live_ff;

endmodule

[sv/canonical_huffman_decoder.sv]
// Canonical Huffman decoder for byte symbols. Load, start and code-bit requests
// are each accepted in the idle state, so an encoded stream can be fed one bit per
// clock while no result is stalled; a decoded symbol (or a bad-code flag after
// MAX_CODE_LEN unmatched bits) shows on the rsp channel in the cycle after the bit
// that completes it, registered out of the sorted-symbol memory read. req_tready
// drops while a result is held by rsp_tready low. A build request sweeps the length
// memory twice (count, then place) around a per-length prefix pass, with
// req_tready low throughout. No clearing pass follows reset: per-entry valid bits
// make the length store read as unused.
module canonical_huffman_decoder import chd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] symbol_value, [12:8] code_length, [13] bit_req, [15:14] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] symbol
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // [0] bad_code
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   chd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (op_type'(req_tuser)),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   chd_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_symbol  (req_tdata[SYM_W-1:0]),
      .in_length  (req_tdata[SYM_W+CLEN_W-1:SYM_W]),
      .in_bit     (req_tdata[SYM_W+CLEN_W]),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_symbol (rsp_tdata),
      .rsp_done   (rsp_tlast),
      .rsp_bad    (rsp_tuser)
   );

endmodule

[sv/chd_checker.sv]
module chd_checker import chd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast,
   input logic                  rsp_tuser,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CFG_W-1:0]      csr_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // no new request while a result is stuck
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   // a fresh result follows a code-bit request
   a_rsp_from_bit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser == OP_BIT))
      else $error("result without a code bit");

   // an error result carries symbol zero and no message end
   a_bad_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0 && !rsp_tlast)
      else $error("malformed error result");

endmodule

bind canonical_huffman_decoder chd_checker u_chd_checker (.*);

[sim/tb_top.sv]
module tb_top;
   import chd_pkg::*;

   localparam int ITEM_GOAL     = 1850;
   localparam int BUILD_CYCLES  = 2*SYMBOL_COUNT + MAX_CODE_LEN + 5;
   localparam int SETTLE_CYCLES = BUILD_CYCLES + 32;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int REPORT_CAP    = 100;

   // shapes of the code set loaded for one phase
   localparam int KIND_TREE   = 0;
   localparam int KIND_SPARSE = 1;
   localparam int KIND_CHAIN  = 2;
   localparam int KIND_FULL   = 3;
   localparam int KIND_BROKEN = 4;

   typedef struct packed {
      bit [7:0] symbol;
      bit       done;
      bit       bad;
   } decode_result_type;

   class huffman_scoreboard_type;
      bit [4:0]          sym_len[SYMBOL_COUNT];
      bit [7:0]          sorted_sym[SYMBOL_COUNT];
      bit [31:0]         first_code[MAX_CODE_LEN+1];
      bit [31:0]         code_count[MAX_CODE_LEN+1];
      bit [31:0]         table_base[MAX_CODE_LEN+1];
      bit [31:0]         run_code;
      int unsigned       run_bits;
      bit [15:0]         emitted;
      bit                stopped;
      bit [15:0]         msg_limit;
      decode_result_type pending_q[$];
      int                mismatches;
      int                live_items;
      int                symbols_seen;
      int                errors_seen;
      int                done_seen;

      function new();
         foreach (sym_len[i]) sym_len[i] = '0;
         foreach (sorted_sym[i]) sorted_sym[i] = '0;
         clear_tables();
         clear_decoder();
         msg_limit = '0;
      endfunction

      function void clear_tables();
         foreach (first_code[i]) begin
            first_code[i] = '0;
            code_count[i] = '0;
            table_base[i] = '0;
         end
      endfunction

      function void clear_decoder();
         run_code = '0;
         run_bits = 0;
         emitted  = '0;
         stopped  = 1'b0;
      endfunction

      // canonical tables: lengths in rising order, symbols by value within a length
      function void rebuild_tables();
         bit [31:0] code;
         int        filled;
         int        count;
         code   = '0;
         filled = 0;
         clear_tables();
         for (int len = 1; len <= MAX_CODE_LEN; len++) begin
            count           = 0;
            first_code[len] = code;
            table_base[len] = filled;
            for (int s = 0; s < SYMBOL_COUNT; s++) begin
               if (sym_len[s] == len) begin
                  sorted_sym[filled % SYMBOL_COUNT] = s[7:0];
                  filled++;
                  count++;
               end
            end
            code_count[len] = count;
            code = (code + count) << 1;
         end
      endfunction

      function void note_request(op_type op, bit [7:0] sv, bit [4:0] cl, bit b);
         bit [31:0]         diff;
         int unsigned       pos;
         decode_result_type r;
         case (op)
            OP_LOAD: begin
               sym_len[sv] = cl;
               live_items++;
            end
            OP_BUILD: begin
               rebuild_tables();
               live_items++;
            end
            OP_START: begin
               clear_decoder();
               live_items++;
            end
            OP_BIT: begin
               if (stopped) return;
               live_items++;
               run_code = {run_code[30:0], b};
               run_bits++;
               if (run_bits <= MAX_CODE_LEN) begin
                  // modulo-2^32 compare also covers code sets that break Kraft
                  diff = run_code - first_code[run_bits];
                  if (diff < code_count[run_bits]) begin
                     pos      = (table_base[run_bits] + diff) % SYMBOL_COUNT;
                     run_code = '0;
                     run_bits = 0;
                     emitted++;
                     r.symbol = sorted_sym[pos];
                     r.done   = 1'b0;
                     r.bad    = 1'b0;
                     if (msg_limit != 0 && emitted == msg_limit) begin
                        r.done  = 1'b1;
                        stopped = 1'b1;
                     end
                     pending_q = {pending_q, r};
                     return;
                  end
               end
               if (run_bits >= MAX_CODE_LEN) begin
                  stopped  = 1'b1;
                  r.symbol = '0;
                  r.done   = 1'b0;
                  r.bad    = 1'b1;
                  pending_q = {pending_q, r};
               end
            end
            default: begin
            end
         endcase
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= REPORT_CAP) $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_result(logic [7:0] sym, logic done, logic bad);
         decode_result_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected result symbol=%0h done=%b bad=%b", sym, done, bad));
            return;
         end
         want = pending_q.pop_front();
         if (sym !== want.symbol)
            report($sformatf("symbol %0h, expected %0h", sym, want.symbol));
         if (done !== want.done)
            report($sformatf("message_done %b, expected %b", done, want.done));
         if (bad !== want.bad)
            report($sformatf("bad_code %b, expected %b", bad, want.bad));
         if (want.bad) errors_seen++;
         else symbols_seen++;
         if (want.done) done_seen++;
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_data;

   huffman_scoreboard_type sb = new();
   bit [7:0]          alphabet[$];
   int                req_calm;
   int                rsp_calm;
   int                cycles;
   int                phases_run;
   int                limits_written;

   canonical_huffman_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // random gap before each request or response slot, with runs of back-to-back traffic
   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) calm = $urandom_range(8, 40);
      return $urandom_range(0, 7);
   endfunction

   task automatic send_req(op_type op, bit [7:0] sv, bit [4:0] cl, bit b);
      int gap;
      gap = pick_gap(req_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {2'b00, b, cl, sv};
      req_tvalid = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_request(op, sv, cl, b);
   endtask

   task automatic send_load(bit [7:0] sv, bit [4:0] cl);
      send_req(OP_LOAD, sv, cl, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_ctl(op_type op);
      send_req(op, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
               1'($urandom_range(0, 1)));
   endtask

   task automatic send_bit(bit b);
      send_req(OP_BIT, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), b);
   endtask

   // encode one symbol from the current tables, msb first; random bit if absent
   task automatic send_symbol(bit [7:0] s);
      int        len;
      bit [31:0] code;
      bit        found;
      len   = int'(sb.sym_len[s]);
      found = 1'b0;
      code  = '0;
      if (len >= 1 && len <= MAX_CODE_LEN) begin
         for (int k = 0; k < sb.code_count[len] && !found; k++) begin
            if (sb.sorted_sym[(sb.table_base[len] + k) % SYMBOL_COUNT] == s) begin
               code  = sb.first_code[len] + k;
               found = 1'b1;
            end
         end
      end
      if (!found) send_bit(1'($urandom_range(0, 1)));
      else for (int i = len - 1; i >= 0; i--) send_bit(code[i]);
   endtask

   // wait out pending results, then a full build walk so the block is idle
   task automatic quiesce();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(bit [15:0] v);
      quiesce();
      @(negedge clock);
      csr_data  = v;
      csr_valid = 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.msg_limit = v;
      limits_written++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic bit [15:0] limit_for(int ph);
      int r;
      if (ph == 0) return 16'hFFFF;
      if (ph == 1) return 16'd1;
      if (ph == 2) return 16'd0;
      r = $urandom_range(0, 9);
      if (r < 2) return 16'd0;
      if (r < 3) return 16'd1;
      if (r < 4) return 16'hFFFF;
      if (r < 7) return 16'($urandom_range(2, 12));
      return 16'($urandom_range(13, 80));
   endfunction

   task automatic load_code_set(int kind);
      bit [7:0] perm[SYMBOL_COUNT];
      bit [4:0] lens[$];
      int       n;
      int       i;
      int       j;
      bit [7:0] t;
      for (int s = 0; s < SYMBOL_COUNT; s++)
         if (sb.sym_len[s] != 0 && (kind != KIND_BROKEN || $urandom_range(0, 1)))
            send_load(8'(s), 5'd0);
      foreach (perm[k]) perm[k] = 8'(k);
      for (i = SYMBOL_COUNT - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = perm[i];
         perm[i] = perm[j];
         perm[j] = t;
      end
      lens.delete();
      case (kind)
         KIND_FULL: repeat (SYMBOL_COUNT) lens = {lens, 5'd8};
         KIND_CHAIN: begin
            for (i = 1; i < MAX_CODE_LEN; i++) lens = {lens, 5'(i)};
            lens = {lens, 5'(MAX_CODE_LEN)};
            lens = {lens, 5'(MAX_CODE_LEN)};
         end
         KIND_TREE, KIND_SPARSE: begin
            // complete prefix code grown by splitting random leaves
            lens = {lens, 5'd1};
            lens = {lens, 5'd1};
            n = $urandom_range(2, 24);
            while (lens.size() < n) begin
               i = $urandom_range(0, lens.size() - 1);
               if (lens[i] < MAX_CODE_LEN) begin
                  lens[i]++;
                  lens = {lens, lens[i]};
               end
            end
            if (kind == KIND_SPARSE)
               repeat ($urandom_range(1, 3))
                  if (lens.size() > 1) lens.delete($urandom_range(0, lens.size() - 1));
         end
         default: begin
            n = $urandom_range(2, 40);
            repeat (n)
               lens = {lens, 5'($urandom_range(0, 3) == 0 ? $urandom_range(17, 31)
                                                          : $urandom_range(1, MAX_CODE_LEN))};
         end
      endcase
      alphabet.delete();
      foreach (lens[k]) begin
         send_load(perm[k], lens[k]);
         if (lens[k] >= 1 && lens[k] <= MAX_CODE_LEN) alphabet = {alphabet, perm[k]};
      end
      repeat ($urandom_range(0, 2))
         send_load(8'($urandom_range(0, 255)), 5'($urandom_range(17, 31)));
      send_ctl(OP_BUILD);
   endtask

   task automatic run_stream(int kind);
      int n;
      int r;
      n = $urandom_range(10, 60);
      repeat (n) begin
         r = $urandom_range(0, 99);
         if ((kind == KIND_BROKEN && r < 70) || (alphabet.size() == 0 && r < 80)) r = 85;
         if (r < 80) begin
            send_symbol(alphabet[$urandom_range(0, alphabet.size() - 1)]);
         end else if (r < 88) begin
            send_bit(1'($urandom_range(0, 1)));
         end else if (r < 93) begin
            send_ctl(OP_START);
         end else if (r < 96) begin
            // table rebuild in the middle of a message
            if ($urandom_range(0, 1))
               send_load(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            send_ctl(OP_BUILD);
         end else begin
            send_load(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
         end
      end
   endtask

   task automatic run_phase(int ph);
      int kind;
      int r;
      if (ph < 3 || $urandom_range(0, 9) < 4) write_limit(limit_for(ph));
      r = $urandom_range(0, 99);
      if (ph == 3) kind = KIND_FULL;
      else if (r < 45) kind = KIND_TREE;
      else if (r < 60) kind = KIND_SPARSE;
      else if (r < 72) kind = KIND_CHAIN;
      else kind = KIND_BROKEN;
      load_code_set(kind);
      // without a start the count carries over, possibly past a new limit
      if ($urandom_range(0, 4) != 0) send_ctl(OP_START);
      run_stream(kind);
   endtask

   initial begin : rsp_sink
      int gap;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         gap = pick_gap(rsp_calm);
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_LOAD;
      csr_valid  = 1'b0;
      csr_data   = '0;
      req_calm   = 0;
      rsp_calm   = 0;
      phases_run = 0;
      limits_written = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no tables yet: a full-length run of bits must end in a bad code, then halt
      repeat (MAX_CODE_LEN) send_bit(1'($urandom_range(0, 1)));
      send_bit(1'b1);
      send_ctl(OP_START);
      send_load(8'hFF, 5'd16);
      send_load(8'h00, 5'd1);
      send_load(8'h07, 5'd31);
      send_ctl(OP_BUILD);
      send_ctl(OP_START);
      send_bit(1'b0);

      while (sb.live_items < ITEM_GOAL) begin
         run_phase(phases_run);
         phases_run++;
      end
      quiesce();

      $display("Decoded %0d symbols, %0d bad codes, %0d end-of-message flags",
               sb.symbols_seen, sb.errors_seen, sb.done_seen);
      $display("%0d live requests over %0d code sets, %0d limit writes, %0d cycles",
               sb.live_items, phases_run, limits_written, cycles);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[canonical_huffman_decoder.f]
sv/chd_pkg.sv
sv/chd_ctrl.sv
sv/chd_datapath.sv
sv/canonical_huffman_decoder.sv
sv/chd_checker.sv
sim/tb_top.sv
